FILE: rtl/xtc_pkg.sv
package xtc_pkg;

    localparam int WINDOW_BYTES_DEF = 9;

    // lexer states, also the encoding of start_state and end_state
    localparam logic [1:0] LX_ROOT    = 2'd0;
    localparam logic [1:0] LX_COMMENT = 2'd1;
    localparam logic [1:0] LX_CDATA   = 2'd2;
    localparam logic [1:0] LX_TAG     = 2'd3;

    localparam logic [2:0] SUB_IDLE    = 3'd0;
    localparam logic [2:0] SUB_ATTR    = 3'd1;
    localparam logic [2:0] SUB_STRING  = 3'd2;
    localparam logic [2:0] SUB_TAGOPEN = 3'd3;
    localparam logic [2:0] SUB_TAGNAME = 3'd4;
    localparam logic [2:0] SUB_CLOSING = 3'd5;

    localparam logic [2:0] COL_NONE      = 3'd0;
    localparam logic [2:0] COL_COMMENT   = 3'd1;
    localparam logic [2:0] COL_STRING    = 3'd2;
    localparam logic [2:0] COL_TAG       = 3'd3;
    localparam logic [2:0] COL_OPERATOR  = 3'd4;
    localparam logic [2:0] COL_ATTRIBUTE = 3'd5;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // patterns written back to front so that byte 0 of the window sits lowest
    localparam logic [31:0] PAT_COMMENT_OPEN  = "--!<";
    localparam logic [71:0] PAT_CDATA_OPEN    = "[ATADC[!<";
    localparam logic [23:0] PAT_COMMENT_CLOSE = ">--";
    localparam logic [23:0] PAT_CDATA_CLOSE   = ">]]";

    localparam logic [3:0] SKIP_COMMENT_OPEN = 4'd3;
    localparam logic [3:0] SKIP_CDATA_OPEN   = 4'd8;
    localparam logic [3:0] SKIP_CLOSE        = 4'd2;

    typedef struct packed {
        logic [1:0] lexer;
        logic [2:0] sub;
        logic [7:0] quote;
        logic [3:0] skip;
    } t_lex_st;

    typedef struct packed {
        logic [2:0] colour;
        logic       line_done;
        logic [1:0] end_state;
    } t_result;

endpackage

FILE: rtl/xtc_classify.sv
module xtc_classify
    import xtc_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic [WINDOW_BYTES-1:0][7:0]          i_win,
    input  logic [$clog2(WINDOW_BYTES+1)-1:0]     i_fill,
    input  t_lex_st                               i_st,
    output logic [2:0]                            o_colour,
    output t_lex_st                               o_st
);

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

    logic [7:0] c;
    logic       m_comment_open;
    logic       m_cdata_open;
    logic       m_comment_close;
    logic       m_cdata_close;
    logic [2:0] sub;
    logic       done;

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_name_char(input logic [7:0] ch);
        return is_alpha(ch) || (ch inside {["0":"9"], ":", "-", ".", "_"});
    endfunction

    assign c = i_win[0];

    assign m_comment_open  = (i_fill >= FILL_W'(4)) && (i_win[3:0] == PAT_COMMENT_OPEN);
    assign m_cdata_open    = (i_fill >= FILL_W'(9)) && (i_win[8:0] == PAT_CDATA_OPEN);
    assign m_comment_close = (i_fill >= FILL_W'(3)) && (i_win[2:0] == PAT_COMMENT_CLOSE);
    assign m_cdata_close   = (i_fill >= FILL_W'(3)) && (i_win[2:0] == PAT_CDATA_CLOSE);

    always_comb begin
        o_st     = i_st;
        o_colour = COL_NONE;
        sub      = i_st.sub;
        done     = 1'b0;
        if (i_st.skip != 4'd0) begin
            case (i_st.lexer)
                LX_COMMENT: o_colour = COL_COMMENT;
                LX_CDATA:   o_colour = COL_STRING;
                default:    o_colour = COL_NONE;
            endcase
            o_st.skip = i_st.skip - 4'd1;
            if (i_st.skip == 4'd1 && i_st.sub == SUB_CLOSING) begin
                o_st.lexer = LX_ROOT;
                o_st.sub   = SUB_IDLE;
            end
        end else begin
            case (i_st.lexer)
                LX_ROOT: begin
                    if (m_comment_open) begin
                        o_st.lexer = LX_COMMENT;
                        o_st.sub   = SUB_IDLE;
                        o_st.skip  = SKIP_COMMENT_OPEN;
                        o_colour   = COL_COMMENT;
                    end else if (m_cdata_open) begin
                        o_st.lexer = LX_CDATA;
                        o_st.sub   = SUB_IDLE;
                        o_st.skip  = SKIP_CDATA_OPEN;
                        o_colour   = COL_STRING;
                    end else if (c == CH_LT) begin
                        o_st.lexer = LX_TAG;
                        o_st.sub   = SUB_TAGOPEN;
                        o_colour   = COL_TAG;
                    end
                end
                LX_COMMENT: begin
                    if (m_comment_close) begin
                        o_st.skip = SKIP_CLOSE;
                        o_st.sub  = SUB_CLOSING;
                    end
                    o_colour = COL_COMMENT;
                end
                LX_CDATA: begin
                    if (m_cdata_close) begin
                        o_st.skip = SKIP_CLOSE;
                        o_st.sub  = SUB_CLOSING;
                    end
                    o_colour = COL_STRING;
                end
                default: begin
                    if (sub == SUB_STRING) begin
                        if (c == i_st.quote) begin
                            o_st.sub = SUB_IDLE;
                        end
                        o_colour = COL_STRING;
                        done     = 1'b1;
                    end
                    if (!done && sub == SUB_TAGOPEN) begin
                        sub = SUB_TAGNAME;
                        if (c == CH_SLASH) begin
                            o_st.sub = SUB_TAGNAME;
                            o_colour = COL_TAG;
                            done     = 1'b1;
                        end
                    end
                    if (!done && sub == SUB_TAGNAME) begin
                        if (is_name_char(c)) begin
                            o_st.sub = SUB_TAGNAME;
                            o_colour = COL_TAG;
                            done     = 1'b1;
                        end else begin
                            sub = SUB_IDLE;
                        end
                    end
                    if (!done && sub == SUB_ATTR) begin
                        if (is_name_char(c)) begin
                            o_st.sub = SUB_ATTR;
                            o_colour = COL_ATTRIBUTE;
                            done     = 1'b1;
                        end
                    end
                    if (!done) begin
                        o_st.sub = SUB_IDLE;
                        if (c == CH_GT) begin
                            o_st.lexer = LX_ROOT;
                            o_colour   = COL_TAG;
                        end else if (c == CH_SLASH) begin
                            o_colour = COL_TAG;
                        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                            o_st.quote = c;
                            o_st.sub   = SUB_STRING;
                            o_colour   = COL_STRING;
                        end else if (c == CH_EQ) begin
                            o_colour = COL_OPERATOR;
                        end else if (is_alpha(c) || c == "_" || c == ":") begin
                            o_st.sub = SUB_ATTR;
                            o_colour = COL_ATTRIBUTE;
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/xml_token_classifier.sv
// xml line colouring lexer
//
// input beats: s_axis_tdata carries one byte of a text line and, on the first
// byte, the state to start the line in; s_axis_tuser marks the first byte and
// s_axis_tlast the last one. output beats: one colour class per byte, in byte
// order; m_axis_tlast marks the line's final byte, whose beat also carries the
// lexer state after the line.
//
// bytes sit in a WINDOW_BYTES deep lookahead window. once it is full, each new
// byte pushes the oldest one out, so inside a line one byte is taken every
// cycle while the output queue has space; a byte's result enters that queue
// when it reaches the front of the window. on the last byte of a line the window
// drains one byte per cycle while the queue has space; input is held off until it is empty.
//
// reset empties the window and puts the lexer in root state. a stalled
// receiver fills a two-entry output queue; after that the window stops
// shifting, and once it is full s_axis_tready drops until space frees up.
module xml_token_classifier
    import xtc_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_byte [7:0], start_state [9:8]
    input  logic        s_axis_tuser,   // first_of_line
    input  logic        s_axis_tlast,   // last_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // colour_class [2:0], end_state [4:3]
    output logic        m_axis_tlast    // line_done
);

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_W  = $clog2(WINDOW_BYTES);

    logic [WINDOW_BYTES-1:0][7:0] r_win, n_win, win_shift;
    logic [FILL_W-1:0]            r_fill, n_fill, fill_pop;
    logic [IDX_W-1:0]             wr_idx;
    logic                         r_drain, n_drain;
    t_lex_st                      r_st, n_st, cls_st;
    logic [2:0]                   cls_colour;
    t_result                      res;
    t_result                      r_q [2];
    logic                         r_wr, r_rd;
    logic [1:0]                   r_cnt;

    logic       in_acc, out_acc, space, pop_en, last_pop, win_full;
    logic [7:0] in_char;
    logic [1:0] in_start;

    assign in_char  = s_axis_tdata[7:0];
    assign in_start = s_axis_tdata[9:8];

    assign win_full      = (r_fill == FILL_W'(WINDOW_BYTES));
    assign space         = (r_cnt != 2'd2);
    assign pop_en        = (win_full || r_drain) && space;
    assign last_pop      = pop_en && r_drain && (r_fill == FILL_W'(1));
    assign s_axis_tready = !r_drain && (!win_full || space);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    xtc_classify #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_classify (
        .i_win    (r_win),
        .i_fill   (r_fill),
        .i_st     (r_st),
        .o_colour (cls_colour),
        .o_st     (cls_st)
    );

    assign res.colour    = cls_colour;
    assign res.line_done = last_pop;
    assign res.end_state = last_pop ? cls_st.lexer : LX_ROOT;

    assign win_shift = {r_win[WINDOW_BYTES-1], r_win[WINDOW_BYTES-1:1]};

    always_comb begin
        fill_pop = pop_en ? (r_fill - FILL_W'(1)) : r_fill;
        wr_idx   = fill_pop[IDX_W-1:0];
        n_win    = pop_en ? win_shift : r_win;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (in_acc) begin
                if (s_axis_tuser) begin
                    if (i == 0) begin
                        n_win[i] = in_char;
                    end
                end else if (IDX_W'(i) == wr_idx) begin
                    n_win[i] = in_char;
                end
            end
        end

        n_fill = fill_pop;
        if (in_acc) begin
            n_fill = s_axis_tuser ? FILL_W'(1) : (fill_pop + FILL_W'(1));
        end

        n_st    = pop_en ? cls_st : r_st;
        n_drain = r_drain;
        if (last_pop) begin
            // line finished: only the lexer state carries over
            n_st.sub   = SUB_IDLE;
            n_st.quote = 8'd0;
            n_st.skip  = 4'd0;
            n_drain    = 1'b0;
        end
        if (in_acc) begin
            if (s_axis_tuser) begin
                n_st.lexer = in_start;
                n_st.sub   = SUB_IDLE;
                n_st.quote = 8'd0;
                n_st.skip  = 4'd0;
            end
            if (s_axis_tlast) begin
                n_drain = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_st    <= '{lexer: LX_ROOT, sub: SUB_IDLE, quote: 8'd0, skip: 4'd0};
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_st    <= n_st;
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (pop_en) begin
            r_q[r_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (pop_en) begin
                r_wr <= ~r_wr;
            end
            if (out_acc) begin
                r_rd <= ~r_rd;
            end
            case ({pop_en, out_acc})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {3'b000, r_q[r_rd].end_state, r_q[r_rd].colour};
    assign m_axis_tlast  = r_q[r_rd].line_done;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(WINDOW_BYTES)) && (!r_drain || r_fill != '0))
        else $error("window fill out of range");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_pop |=> (!r_drain && r_fill == '0))
        else $error("window not empty after line end");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=> (r_drain && !s_axis_tready))
        else $error("line end beat did not start a drain");

    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.skip <= SKIP_CDATA_OPEN)
        else $error("skip count out of range");

endmodule

FILE: tb/xml_token_classifier_tb.sv
`timescale 1ns / 1ps

module xml_token_classifier_tb
    import xtc_pkg::*;
();

    localparam int HALF_PERIOD   = 10;
    localparam int BYTE_TARGET   = 300;
    localparam int HOLD_AT_BEAT  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4 * WINDOW_BYTES_DEF + 20;

    typedef logic [7:0] t_text[$];

    // shadow of the lexer: predicts one colour beat per byte, in byte order
    class lexer_shadow;
        logic [7:0]  held[WINDOW_BYTES_DEF];
        int unsigned held_count;
        logic [1:0]  lexer;
        logic [2:0]  sub;
        logic [7:0]  quote;
        logic [3:0]  skip;
        t_result     colours_due[$];
        int unsigned mismatch_count;

        function new();
            held_count     = 0;
            lexer          = LX_ROOT;
            sub            = SUB_IDLE;
            quote          = '0;
            skip           = '0;
            mismatch_count = 0;
        endfunction

        function bit head_is(logic [71:0] pat, int unsigned n);
            if (n > held_count)
                return 1'b0;
            for (int i = 0; i < n; i++)
                if (held[i] != pat[8*i +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_name_byte(logic [7:0] c);
            return is_letter(c) || (c >= "0" && c <= "9") || c == ":" || c == "-" ||
                   c == "." || c == "_";
        endfunction

        function logic [2:0] colour_in_tag(logic [7:0] c);
            if (sub == SUB_STRING) begin
                if (c == quote)
                    sub = SUB_IDLE;
                return COL_STRING;
            end
            if (sub == SUB_TAGOPEN) begin
                sub = SUB_TAGNAME;
                if (c == CH_SLASH)
                    return COL_TAG;
            end
            if (sub == SUB_TAGNAME) begin
                if (is_name_byte(c))
                    return COL_TAG;
                sub = SUB_IDLE;
            end
            if (sub == SUB_ATTR) begin
                if (is_name_byte(c))
                    return COL_ATTRIBUTE;
                sub = SUB_IDLE;
            end
            sub = SUB_IDLE;
            if (c == CH_GT) begin
                lexer = LX_ROOT;
                return COL_TAG;
            end
            if (c == CH_SLASH)
                return COL_TAG;
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                quote = c;
                sub   = SUB_STRING;
                return COL_STRING;
            end
            if (c == CH_EQ)
                return COL_OPERATOR;
            if (is_letter(c) || c == "_" || c == ":") begin
                sub = SUB_ATTR;
                return COL_ATTRIBUTE;
            end
            return COL_NONE;
        endfunction

        function logic [2:0] colour_of_head();
            logic [2:0] col;
            if (skip != 0) begin
                col = (lexer == LX_COMMENT) ? COL_COMMENT :
                      (lexer == LX_CDATA)   ? COL_STRING  : COL_NONE;
                skip = skip - 4'd1;
                if (skip == 0 && sub == SUB_CLOSING) begin
                    lexer = LX_ROOT;
                    sub   = SUB_IDLE;
                end
                return col;
            end
            case (lexer)
                LX_ROOT: begin
                    if (head_is(PAT_COMMENT_OPEN, 4)) begin
                        lexer = LX_COMMENT;
                        sub   = SUB_IDLE;
                        skip  = SKIP_COMMENT_OPEN;
                        return COL_COMMENT;
                    end
                    if (head_is(PAT_CDATA_OPEN, 9)) begin
                        lexer = LX_CDATA;
                        sub   = SUB_IDLE;
                        skip  = SKIP_CDATA_OPEN;
                        return COL_STRING;
                    end
                    if (held[0] == CH_LT) begin
                        lexer = LX_TAG;
                        sub   = SUB_TAGOPEN;
                        return COL_TAG;
                    end
                    return COL_NONE;
                end
                LX_COMMENT: begin
                    if (head_is(PAT_COMMENT_CLOSE, 3)) begin
                        skip = SKIP_CLOSE;
                        sub  = SUB_CLOSING;
                    end
                    return COL_COMMENT;
                end
                LX_CDATA: begin
                    if (head_is(PAT_CDATA_CLOSE, 3)) begin
                        skip = SKIP_CLOSE;
                        sub  = SUB_CLOSING;
                    end
                    return COL_STRING;
                end
                default: begin
                    return colour_in_tag(held[0]);
                end
            endcase
        endfunction

        function logic [2:0] shift_out_head();
            logic [2:0] col;
            col = colour_of_head();
            for (int i = 0; i + 1 < held_count; i++)
                held[i] = held[i + 1];
            held_count--;
            return col;
        endfunction

        function void take_byte(logic [7:0] ch, logic is_first, logic [1:0] st,
                                logic is_last);
            logic [2:0] col;
            if (is_first) begin
                // a new line drops whatever the unfinished one still holds
                held_count = 0;
                lexer      = st;
                sub        = SUB_IDLE;
                skip       = '0;
                quote      = '0;
            end
            held[held_count] = ch;
            held_count++;
            if (is_last) begin
                while (held_count > 0) begin
                    col = shift_out_head();
                    if (held_count == 0)
                        colours_due.push_back('{colour: col, line_done: 1'b1,
                                                end_state: lexer});
                    else
                        colours_due.push_back('{colour: col, line_done: 1'b0,
                                                end_state: LX_ROOT});
                end
                sub   = SUB_IDLE;
                skip  = '0;
                quote = '0;
            end else if (held_count == WINDOW_BYTES_DEF) begin
                col = shift_out_head();
                colours_due.push_back('{colour: col, line_done: 1'b0, end_state: LX_ROOT});
            end
        endfunction

        function void match_colour(t_result got);
            t_result want;
            if (colours_due.size() == 0) begin
                $error("colour beat with nothing due: colour_class %0d line_done %0d end_state %0d",
                       got.colour, got.line_done, got.end_state);
                mismatch_count++;
                return;
            end
            want = colours_due.pop_front();
            if (got.colour !== want.colour) begin
                $error("colour_class: expected %0d, got %0d", want.colour, got.colour);
                mismatch_count++;
            end
            if (got.line_done !== want.line_done) begin
                $error("line_done: expected %0d, got %0d", want.line_done, got.line_done);
                mismatch_count++;
            end
            if (got.end_state !== want.end_state) begin
                $error("end_state: expected %0d, got %0d", want.end_state, got.end_state);
                mismatch_count++;
            end
        endfunction

        function int unsigned beats_due();
            return colours_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // char_byte [7:0], start_state [9:8]
    logic        s_axis_tuser;   // first_of_line
    logic        s_axis_tlast;   // last_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // colour_class [2:0], end_state [4:3]
    logic        m_axis_tlast;   // line_done

    lexer_shadow book = new();
    int unsigned bytes_sent = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;

    xml_token_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void add_text(ref t_text txt, input string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endfunction

    function automatic void add_name(ref t_text txt);
        string pool;
        int    n;
        pool = "abxyzQRZ0179:-._";
        n    = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            txt.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endfunction

    function automatic t_text text_of(string s);
        t_text txt;
        add_text(txt, s);
        return txt;
    endfunction

    // mostly markup fragments so that tags, comments and cdata sections get opened
    // and closed; cutting to length splits openers and closers now and then
    function automatic t_text random_markup(int target);
        t_text txt;
        while (txt.size() < target) begin
            case ($urandom_range(0, 15))
                0, 1: begin
                    txt.push_back(CH_LT);
                    add_name(txt);
                end
                2: begin
                    add_text(txt, " ");
                    add_name(txt);
                    txt.push_back(CH_EQ);
                end
                3: begin
                    txt.push_back(CH_DQUOTE);
                    add_name(txt);
                    txt.push_back(CH_DQUOTE);
                end
                4: begin
                    txt.push_back(CH_SQUOTE);
                    add_name(txt);
                    txt.push_back(CH_SQUOTE);
                end
                5: txt.push_back(CH_GT);
                6: begin
                    add_text(txt, "</");
                    add_name(txt);
                    txt.push_back(CH_GT);
                end
                7: add_text(txt, "<!--");
                8: add_text(txt, "-->");
                9: add_text(txt, "<![CDATA[");
                10: add_text(txt, "]]>");
                11: begin
                    add_text(txt, " ");
                    add_name(txt);
                end
                12: txt.push_back(8'($urandom_range(0, 255)));
                13: add_text(txt, "/>");
                14: txt.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                default: add_text(txt, " ");
            endcase
        end
        while (txt.size() > target)
            void'(txt.pop_back());
        return txt;
    endfunction

    task automatic send_byte(logic [7:0] ch, logic is_first, logic [1:0] st, logic is_last);
        int gap;
        if ($urandom_range(0, 23) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, st, ch};
        s_axis_tuser  <= is_first;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        book.take_byte(ch, is_first, st, is_last);
        bytes_sent++;
    endtask

    task automatic send_line(t_text txt, bit with_first, logic [1:0] st, bit with_last);
        logic [1:0] st_bits;
        for (int i = 0; i < txt.size(); i++) begin
            // start_state only counts on the first beat; elsewhere it carries noise
            st_bits = (i == 0) ? st : 2'($urandom_range(0, 3));
            send_byte(txt[i], with_first && i == 0, st_bits,
                      with_last && i == txt.size() - 1);
        end
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int          gap;
        int unsigned beats_taken;
        beats_taken   = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats_taken == HOLD_AT_BEAT)
                gap = HOLD_CYCLES;
            else begin
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                gap = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            book.match_colour('{colour: m_axis_tdata[2:0], line_done: m_axis_tlast,
                                end_state: m_axis_tdata[4:3]});
            beats_taken++;
        end
    end

    initial begin
        int         target;
        int         roll;
        bit         with_first;
        bit         with_last;
        logic [1:0] st;
        t_text      edge_bytes;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte lines at the byte extremes
        edge_bytes = {8'h00};
        send_line(edge_bytes, 1'b1, LX_CDATA, 1'b1);
        edge_bytes = {8'hFF};
        send_line(edge_bytes, 1'b1, LX_TAG, 1'b1);
        // tag name, attribute, operator and a quote left open at line end
        send_line(text_of("<a b='x"), 1'b1, LX_ROOT, 1'b1);
        // carries on in tag state without a line start
        send_line(text_of("/>"), 1'b0, LX_ROOT, 1'b1);
        send_line(text_of("-->"), 1'b1, LX_COMMENT, 1'b1);
        send_line(text_of("]]>"), 1'b1, LX_CDATA, 1'b1);
        // unfinished line, dropped by the next line start
        send_line(text_of("<!--<"), 1'b1, LX_ROOT, 1'b0);
        send_line(text_of("<![CDATA["), 1'b1, LX_ROOT, 1'b1);

        while (bytes_sent < BYTE_TARGET) begin
            target     = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 18);
            roll       = $urandom_range(0, 99);
            with_first = roll >= 7;
            with_last  = roll < 93;
            st         = ($urandom_range(0, 9) < 7) ? book.lexer : 2'($urandom_range(0, 3));
            send_line(random_markup(target), with_first, st, with_last);
        end
        send_line(random_markup($urandom_range(1, 12)), 1'b1, 2'($urandom_range(0, 3)), 1'b1);
        s_axis_tvalid <= 1'b0;

        while (book.beats_due() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
